// ===== hdl/lka_pkg.sv =====
// Package for the luma keyer: field widths, full-scale constant, key modes,
// register indexes and the per-beat sideband struct. No dependencies.
package lka_pkg;

   localparam int PIXEL_BITS = 16;
   localparam int FIELD_W    = 16;
   localparam int QUOT_W     = PIXEL_BITS;
   localparam int PROD_W     = FIELD_W + PIXEL_BITS;
   localparam int CSR_IDX_W  = 2;

   localparam logic [PIXEL_BITS-1:0] FULL_SCALE = {PIXEL_BITS{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_BLACK_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE_LEVEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFT_WIDTH  = 2'd2;

   localparam logic [FIELD_W-1:0] BLACK_LEVEL_RESET = 16'd0;
   localparam logic [FIELD_W-1:0] WHITE_LEVEL_RESET = 16'd2;
   localparam logic [FIELD_W-1:0] SOFT_WIDTH_RESET  = 16'd0;

   typedef enum logic [1:0] {
      KEY_PASS,
      KEY_ZERO,
      KEY_BELOW,
      KEY_ABOVE
   } key_mode_type;

   typedef struct packed {
      key_mode_type        mode;
      logic [FIELD_W-1:0]  alpha;
   } side_type;

endpackage

// ===== hdl/lka_classify.sv =====
// First pipeline stage of the luma keyer: compares the luma against the key
// band and the soft ramps and forms the ramp numerator. Uses lka_pkg.
module lka_classify (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [lka_pkg::FIELD_W-1:0] luma,
   input  logic [lka_pkg::FIELD_W-1:0] alpha,
   input  logic [lka_pkg::FIELD_W-1:0] black_level,
   input  logic [lka_pkg::FIELD_W-1:0] white_level,
   input  logic [lka_pkg::FIELD_W-1:0] soft_width,
   output logic                    out_valid,
   input  logic                    out_ready,
   output lka_pkg::side_type       out_side,
   output logic [lka_pkg::FIELD_W-1:0] out_num
);

   logic                        valid_ff;
   lka_pkg::side_type           side_ff;
   lka_pkg::side_type           side_in;
   logic [lka_pkg::FIELD_W-1:0] num_ff;
   logic [lka_pkg::FIELD_W-1:0] num_in;
   logic [lka_pkg::FIELD_W:0]   luma_plus_soft;
   logic [lka_pkg::FIELD_W:0]   white_plus_soft;
   logic                        in_band;
   logic                        in_ramp;

   always_comb begin
      luma_plus_soft  = {1'b0, luma} + {1'b0, soft_width};
      white_plus_soft = {1'b0, white_level} + {1'b0, soft_width};
      in_band = (luma >= black_level) && (luma <= white_level);
      in_ramp = (soft_width != '0) && (luma_plus_soft > {1'b0, black_level}) &&
                ({1'b0, luma} < white_plus_soft);
      side_in.alpha = alpha;
      num_in = '0;
      if (in_band) begin
         side_in.mode = lka_pkg::KEY_ZERO;
      end else if (in_ramp) begin
         if (luma < black_level) begin
            side_in.mode = lka_pkg::KEY_BELOW;
            num_in = lka_pkg::FIELD_W'(luma_plus_soft - {1'b0, black_level});
         end else begin
            side_in.mode = lka_pkg::KEY_ABOVE;
            num_in = luma - white_level;
         end
      end else begin
         side_in.mode = lka_pkg::KEY_PASS;
      end
   end

   assign in_ready = ~valid_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         side_ff <= side_in;
         num_ff  <= num_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_num   = num_ff;

endmodule

// ===== hdl/lka_div_step.sv =====
// One restoring-division stage: compares the partial remainder with the
// shifted soft width and produces one quotient bit. Uses lka_pkg.
module lka_div_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  lka_pkg::side_type           in_side,
   input  logic [lka_pkg::PROD_W-1:0]  in_rem,
   input  logic [lka_pkg::QUOT_W-1:0]  in_quot,
   input  logic [lka_pkg::PROD_W-1:0]  divisor,
   output logic                        out_valid,
   input  logic                        out_ready,
   output lka_pkg::side_type           out_side,
   output logic [lka_pkg::PROD_W-1:0]  out_rem,
   output logic [lka_pkg::QUOT_W-1:0]  out_quot
);

   logic                         valid_ff;
   lka_pkg::side_type            side_ff;
   logic [lka_pkg::PROD_W-1:0]   rem_ff;
   logic [lka_pkg::PROD_W-1:0]   rem_in;
   logic [lka_pkg::QUOT_W-1:0]   quot_ff;
   logic [lka_pkg::QUOT_W-1:0]   quot_in;
   logic                         fits;

   always_comb begin
      fits    = in_rem >= divisor;
      rem_in  = fits ? (in_rem - divisor) : in_rem;
      quot_in = {in_quot[lka_pkg::QUOT_W-2:0], fits};
   end

   assign in_ready = ~valid_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         side_ff <= in_side;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_quot  = quot_ff;

endmodule

// ===== hdl/lka_div.sv =====
// Ramp arithmetic of the luma keyer: a registered multiply by full scale,
// then one lka_div_step per quotient bit. Uses lka_pkg and lka_div_step.
module lka_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  lka_pkg::side_type           in_side,
   input  logic [lka_pkg::FIELD_W-1:0] in_num,
   input  logic [lka_pkg::FIELD_W-1:0] soft_width,
   output logic                        out_valid,
   input  logic                        out_ready,
   output lka_pkg::side_type           out_side,
   output logic [lka_pkg::QUOT_W-1:0]  out_quot
);

   logic                         mul_valid_ff;
   lka_pkg::side_type            mul_side_ff;
   logic [lka_pkg::PROD_W-1:0]   mul_prod_ff;
   logic [lka_pkg::PROD_W-1:0]   mul_prod_in;

   logic                         step_valid [lka_pkg::QUOT_W+1];
   logic                         step_ready [lka_pkg::QUOT_W+1];
   lka_pkg::side_type            step_side  [lka_pkg::QUOT_W+1];
   logic [lka_pkg::PROD_W-1:0]   step_rem   [lka_pkg::QUOT_W+1];
   logic [lka_pkg::QUOT_W-1:0]   step_quot  [lka_pkg::QUOT_W+1];

   assign mul_prod_in = lka_pkg::PROD_W'(in_num) * lka_pkg::PROD_W'(lka_pkg::FULL_SCALE);
   assign in_ready    = ~mul_valid_ff | step_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (in_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         mul_side_ff <= in_side;
         mul_prod_ff <= mul_prod_in;
      end
   end

   assign step_valid[0] = mul_valid_ff;
   assign step_side[0]  = mul_side_ff;
   assign step_rem[0]   = mul_prod_ff;
   assign step_quot[0]  = '0;

   for (genvar i = 0; i < lka_pkg::QUOT_W; i++) begin : g_step
      lka_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (step_valid[i]),
         .in_ready  (step_ready[i]),
         .in_side   (step_side[i]),
         .in_rem    (step_rem[i]),
         .in_quot   (step_quot[i]),
         .divisor   (lka_pkg::PROD_W'(soft_width) << (lka_pkg::QUOT_W - 1 - i)),
         .out_valid (step_valid[i+1]),
         .out_ready (step_ready[i+1]),
         .out_side  (step_side[i+1]),
         .out_rem   (step_rem[i+1]),
         .out_quot  (step_quot[i+1])
      );
   end

   assign out_valid                     = step_valid[lka_pkg::QUOT_W];
   assign step_ready[lka_pkg::QUOT_W]   = out_ready;
   assign out_side                      = step_side[lka_pkg::QUOT_W];
   assign out_quot                      = step_quot[lka_pkg::QUOT_W];

endmodule

// ===== hdl/luma_key_alpha_core.sv =====
// Luma keyer with soft ramps: one beat per cycle sustained while the result
// side keeps taking beats.
// Stages: band compare, multiply by full scale, one stage per quotient bit
// of the pipelined divider, output register. Every stage has its own valid
// bit and fills bubbles while the output stalls.
// Synchronous reset empties the pipeline and restores the register defaults.
module luma_key_alpha_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lka_pkg::FIELD_W-1:0]     req_luma_in,
   input  logic [lka_pkg::FIELD_W-1:0]     req_alpha_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lka_pkg::FIELD_W-1:0]     rsp_alpha_out,
   input  logic                            csr_we,
   input  logic [lka_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lka_pkg::FIELD_W-1:0]     csr_wdata
);

   logic [lka_pkg::FIELD_W-1:0] black_level_ff;
   logic [lka_pkg::FIELD_W-1:0] white_level_ff;
   logic [lka_pkg::FIELD_W-1:0] soft_width_ff;

   logic                        cls_valid;
   logic                        cls_ready;
   lka_pkg::side_type           cls_side;
   logic [lka_pkg::FIELD_W-1:0] cls_num;

   logic                        div_valid;
   logic                        div_ready;
   lka_pkg::side_type           div_side;
   logic [lka_pkg::QUOT_W-1:0]  div_quot;

   logic                        rsp_valid_ff;
   logic [lka_pkg::FIELD_W-1:0] rsp_alpha_ff;
   logic [lka_pkg::FIELD_W-1:0] rsp_alpha_in;
   logic [lka_pkg::FIELD_W-1:0] quot_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         black_level_ff <= lka_pkg::BLACK_LEVEL_RESET;
         white_level_ff <= lka_pkg::WHITE_LEVEL_RESET;
         soft_width_ff  <= lka_pkg::SOFT_WIDTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lka_pkg::CSR_BLACK_LEVEL: black_level_ff <= csr_wdata;
            lka_pkg::CSR_WHITE_LEVEL: white_level_ff <= csr_wdata;
            lka_pkg::CSR_SOFT_WIDTH:  soft_width_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   lka_classify u_classify (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .luma        (req_luma_in),
      .alpha       (req_alpha_in),
      .black_level (black_level_ff),
      .white_level (white_level_ff),
      .soft_width  (soft_width_ff),
      .out_valid   (cls_valid),
      .out_ready   (cls_ready),
      .out_side    (cls_side),
      .out_num     (cls_num)
   );

   lka_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cls_valid),
      .in_ready   (cls_ready),
      .in_side    (cls_side),
      .in_num     (cls_num),
      .soft_width (soft_width_ff),
      .out_valid  (div_valid),
      .out_ready  (div_ready),
      .out_side   (div_side),
      .out_quot   (div_quot)
   );

   always_comb begin
      quot_ext = lka_pkg::FIELD_W'(div_quot);
      unique case (div_side.mode)
         lka_pkg::KEY_PASS:  rsp_alpha_in = div_side.alpha;
         lka_pkg::KEY_ZERO:  rsp_alpha_in = '0;
         lka_pkg::KEY_BELOW: rsp_alpha_in = lka_pkg::FIELD_W'(lka_pkg::FULL_SCALE) - quot_ext;
         lka_pkg::KEY_ABOVE: rsp_alpha_in = quot_ext;
         default:            rsp_alpha_in = div_side.alpha;
      endcase
   end

   assign div_ready = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready && div_valid) begin
         rsp_alpha_ff <= rsp_alpha_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_alpha_out = rsp_alpha_ff;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for luma_key_alpha_core: directed pixel table, then
// randomized key settings and pixels, each beat checked against a fixed
// expected value or a keyer model. Depends on lka_pkg and the luma_key_alpha_core RTL.
module testbench;

   localparam logic [lka_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS = 10;

   typedef enum logic [0:0] {
      ROW_PIXEL,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type                  kind;
      logic [lka_pkg::CSR_IDX_W-1:0] index;
      logic [lka_pkg::FIELD_W-1:0]   data;
      logic [lka_pkg::FIELD_W-1:0]   alpha;
      bit                            fixed;
      logic [lka_pkg::FIELD_W-1:0]   want;
   } pixel_vec_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [lka_pkg::FIELD_W-1:0]   req_luma_in;
   logic [lka_pkg::FIELD_W-1:0]   req_alpha_in;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [lka_pkg::FIELD_W-1:0]   rsp_alpha_out;
   logic                          csr_we;
   logic [lka_pkg::CSR_IDX_W-1:0] csr_index;
   logic [lka_pkg::FIELD_W-1:0]   csr_wdata;

   logic [lka_pkg::FIELD_W-1:0]   black_lvl;
   logic [lka_pkg::FIELD_W-1:0]   white_lvl;
   logic [lka_pkg::FIELD_W-1:0]   soft_wid;
   logic [lka_pkg::FIELD_W-1:0]   expected_alpha [$];
   pixel_vec_type                 directed_rows [$];
   int                            n_errors;
   bit                            calm;
   bit                            hold_rsp;

   logic [lka_pkg::FIELD_W-1:0]   cfg_black;
   logic [lka_pkg::FIELD_W-1:0]   cfg_white;
   logic [lka_pkg::FIELD_W-1:0]   cfg_soft;
   logic [lka_pkg::FIELD_W-1:0]   luma;
   logic [lka_pkg::FIELD_W-1:0]   alpha;
   int                            pick;
   int                            n_items;

   luma_key_alpha_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_luma_in   (req_luma_in),
      .req_alpha_in  (req_alpha_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_alpha_out (rsp_alpha_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [lka_pkg::FIELD_W-1:0] keyed_alpha(
         logic [lka_pkg::FIELD_W-1:0] luma_v,
         logic [lka_pkg::FIELD_W-1:0] alpha_v);
      longint l;
      longint b;
      longint w;
      longint s;
      longint full;
      l = longint'(luma_v);
      b = longint'(black_lvl);
      w = longint'(white_lvl);
      s = longint'(soft_wid);
      full = longint'(lka_pkg::FULL_SCALE);
      if (l >= b && l <= w)
         return '0;
      if (s != 0 && l > b - s && l < w + s) begin
         if (l < b)
            return lka_pkg::FIELD_W'(full - ((l - b + s) * full) / s);
         return lka_pkg::FIELD_W'(((l - w) * full) / s);
      end
      return alpha_v;
   endfunction

   function automatic void apply_register(logic [lka_pkg::CSR_IDX_W-1:0] index,
                                          logic [lka_pkg::FIELD_W-1:0] data);
      unique case (index)
         lka_pkg::CSR_BLACK_LEVEL: black_lvl = data;
         lka_pkg::CSR_WHITE_LEVEL: white_lvl = data;
         lka_pkg::CSR_SOFT_WIDTH:  soft_wid = data;
         default: ;
      endcase
   endfunction

   function automatic void pixel_row(logic [lka_pkg::FIELD_W-1:0] luma_v,
                                     logic [lka_pkg::FIELD_W-1:0] alpha_v,
                                     bit fixed, logic [lka_pkg::FIELD_W-1:0] want);
      pixel_vec_type row;
      row.kind = ROW_PIXEL;
      row.index = '0;
      row.data = luma_v;
      row.alpha = alpha_v;
      row.fixed = fixed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void csr_row(logic [lka_pkg::CSR_IDX_W-1:0] index,
                                   logic [lka_pkg::FIELD_W-1:0] data);
      pixel_vec_type row;
      row.kind = ROW_CSR;
      row.index = index;
      row.data = data;
      row.alpha = '0;
      row.fixed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endfunction

   task automatic note_error(input string msg);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
         $display("%0t: %s", $realtime, msg);
   endtask

   task automatic send_pixel(input logic [lka_pkg::FIELD_W-1:0] luma_v,
                             input logic [lka_pkg::FIELD_W-1:0] alpha_v,
                             input logic [lka_pkg::FIELD_W-1:0] want);
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_luma_in <= luma_v;
      req_alpha_in <= alpha_v;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      expected_alpha.push_back(want);
   endtask

   task automatic write_csr(input logic [lka_pkg::CSR_IDX_W-1:0] index,
                            input logic [lka_pkg::FIELD_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_register(index, data);
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_alpha.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(99) >= 27);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_alpha.size() == 0) begin
            note_error($sformatf("unexpected beat, alpha_out %h", rsp_alpha_out));
         end else if (rsp_alpha_out !== expected_alpha[0]) begin
            note_error($sformatf("alpha_out mismatch: expected %h, got %h",
                                 expected_alpha[0], rsp_alpha_out));
            void'(expected_alpha.pop_front());
         end else begin
            void'(expected_alpha.pop_front());
         end
      end
   end

   initial begin
      #2_000_000;
      $display("** luma_key_alpha_core: FAILED **");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_luma_in = '0;
      req_alpha_in = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm = 1'b0;
      hold_rsp = 1'b0;
      n_errors = 0;
      black_lvl = lka_pkg::BLACK_LEVEL_RESET;
      white_lvl = lka_pkg::WHITE_LEVEL_RESET;
      soft_wid = lka_pkg::SOFT_WIDTH_RESET;

      // Reset settings: band [0, 2], no ramps.
      pixel_row(16'h0000, 16'hFFFF, 1, 16'h0000);
      pixel_row(16'h0002, 16'h1234, 1, 16'h0000);
      pixel_row(16'h0003, 16'hABCD, 1, 16'hABCD);
      pixel_row(16'hFFFF, 16'hFFFF, 1, 16'hFFFF);
      pixel_row(16'hFFFF, 16'h0000, 1, 16'h0000);
      csr_row(lka_pkg::CSR_BLACK_LEVEL, 16'd100);
      csr_row(lka_pkg::CSR_WHITE_LEVEL, 16'd200);
      csr_row(lka_pkg::CSR_SOFT_WIDTH, 16'd50);
      pixel_row(16'd100, 16'h5A5A, 1, 16'h0000);
      pixel_row(16'd200, 16'h5A5A, 1, 16'h0000);
      pixel_row(16'd99, 16'h5A5A, 0, '0);
      pixel_row(16'd50, 16'hA5A5, 1, 16'hA5A5);
      pixel_row(16'd51, 16'h5A5A, 0, '0);
      pixel_row(16'd201, 16'h5A5A, 0, '0);
      pixel_row(16'd249, 16'h5A5A, 0, '0);
      pixel_row(16'd250, 16'hA5A5, 1, 16'hA5A5);
      // Black above white: empty band, ramps over almost the whole range.
      csr_row(lka_pkg::CSR_BLACK_LEVEL, 16'hFFFF);
      csr_row(lka_pkg::CSR_WHITE_LEVEL, 16'h0000);
      csr_row(lka_pkg::CSR_SOFT_WIDTH, 16'hFFFF);
      pixel_row(16'h0000, 16'h0F0F, 1, 16'h0F0F);
      pixel_row(16'hFFFF, 16'hF0F0, 1, 16'hF0F0);
      pixel_row(16'h8000, 16'h0F0F, 0, '0);
      pixel_row(16'h0001, 16'h0F0F, 0, '0);
      pixel_row(16'hFFFE, 16'h0F0F, 0, '0);
      // A write to an unmapped index must leave the settings alone.
      csr_row(CSR_UNMAPPED, 16'h0000);
      pixel_row(16'h7FFF, 16'h0F0F, 0, '0);
      csr_row(lka_pkg::CSR_BLACK_LEVEL, 16'h0000);
      csr_row(lka_pkg::CSR_WHITE_LEVEL, 16'hFFFF);
      csr_row(lka_pkg::CSR_SOFT_WIDTH, 16'h0001);
      pixel_row(16'h5555, 16'hFFFF, 1, 16'h0000);
      csr_row(lka_pkg::CSR_BLACK_LEVEL, 16'h8000);
      csr_row(lka_pkg::CSR_WHITE_LEVEL, 16'h8000);
      pixel_row(16'h7FFF, 16'h3C3C, 1, 16'h3C3C);
      pixel_row(16'h8000, 16'h3C3C, 1, 16'h0000);
      csr_row(lka_pkg::CSR_SOFT_WIDTH, 16'hFFFF);
      pixel_row(16'h0000, 16'h3C3C, 0, '0);
      pixel_row(16'hFFFF, 16'h3C3C, 0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(directed_rows[i].index, directed_rows[i].data);
         end else begin
            send_pixel(directed_rows[i].data, directed_rows[i].alpha,
                       directed_rows[i].fixed ? directed_rows[i].want :
                       keyed_alpha(directed_rows[i].data, directed_rows[i].alpha));
         end
      end

      for (int phase = 0; phase < 11; phase++) begin
         wait_idle();
         case (phase % 6)
            0: begin
               cfg_black = lka_pkg::FIELD_W'($urandom);
               cfg_white = cfg_black + lka_pkg::FIELD_W'($urandom_range(0, 3000));
               cfg_soft = lka_pkg::FIELD_W'($urandom_range(1, 2000));
            end
            1: begin
               cfg_black = lka_pkg::FIELD_W'($urandom);
               cfg_white = lka_pkg::FIELD_W'($urandom);
               cfg_soft = lka_pkg::FIELD_W'($urandom);
            end
            2: begin
               cfg_black = lka_pkg::FIELD_W'($urandom);
               cfg_white = lka_pkg::FIELD_W'($urandom);
               cfg_soft = '0;
            end
            3: begin
               cfg_black = '0;
               cfg_white = '0;
               cfg_soft = 16'hFFFF;
            end
            4: begin
               cfg_black = 16'hFFFF;
               cfg_white = 16'hFFFF;
               cfg_soft = lka_pkg::FIELD_W'($urandom_range(1, 3));
            end
            default: begin
               cfg_black = lka_pkg::FIELD_W'($urandom);
               cfg_white = lka_pkg::FIELD_W'($urandom);
               cfg_soft = 16'd1;
            end
         endcase
         write_csr(lka_pkg::CSR_BLACK_LEVEL, cfg_black);
         write_csr(lka_pkg::CSR_WHITE_LEVEL, cfg_white);
         write_csr(lka_pkg::CSR_SOFT_WIDTH, cfg_soft);
         if ($urandom_range(0, 1))
            write_csr(CSR_UNMAPPED, lka_pkg::FIELD_W'($urandom));
         calm = (phase == 4);
         if (phase == 7)
            hold_rsp = 1'b1;
         n_items = calm ? 100 : 40;
         for (int k = 0; k < n_items; k++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: pick = int'(black_lvl) - int'(soft_wid) - 2 +
                                  int'($urandom_range(0, int'(soft_wid) + 4));
               4, 5, 6: pick = int'(white_lvl) - 2 +
                               int'($urandom_range(0, int'(soft_wid) + 4));
               7: begin
                  case ($urandom_range(0, 7))
                     0: pick = int'(black_lvl) - int'(soft_wid);
                     1: pick = int'(black_lvl) - int'(soft_wid) + 1;
                     2: pick = int'(black_lvl) - 1;
                     3: pick = int'(black_lvl);
                     4: pick = int'(white_lvl);
                     5: pick = int'(white_lvl) + 1;
                     6: pick = int'(white_lvl) + int'(soft_wid) - 1;
                     default: pick = int'(white_lvl) + int'(soft_wid);
                  endcase
               end
               default: pick = int'($urandom);
            endcase
            luma = pick[lka_pkg::FIELD_W-1:0];
            alpha = lka_pkg::FIELD_W'($urandom);
            send_pixel(luma, alpha, keyed_alpha(luma, alpha));
         end
      end

      calm = 1'b0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errors == 0 && expected_alpha.size() == 0)
         $display("** luma_key_alpha_core: PASSED **");
      else
         $display("** luma_key_alpha_core: FAILED **");
      $finish;
   end

endmodule

// ===== luma_key_alpha_core.f =====
hdl/lka_pkg.sv
hdl/lka_classify.sv
hdl/lka_div_step.sv
hdl/lka_div.sv
hdl/luma_key_alpha_core.sv
verif/testbench.sv
